// ===== sv/ptbta_pkg.sv =====
package ptbta_pkg;

  localparam int MAX_TRACKS = 16;
  localparam int SLOT_W     = $clog2(MAX_TRACKS);
  localparam int CNT_W      = SLOT_W + 1;

  localparam int OPND_W = 18;   // signed operand of the squaring unit
  localparam int ACC_W  = 35;   // squares and their sums
  localparam int RAD_W  = 34;   // radicand of the square root
  localparam int ROOT_W = 17;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_EOF   = 2'd2;

  localparam logic [1:0] CFG_MARGIN_XY = 2'd0;
  localparam logic [1:0] CFG_MARGIN_Z  = 2'd1;
  localparam logic [1:0] CFG_RADIUS    = 2'd2;
  localparam logic [1:0] CFG_MIN_PTS   = 2'd3;

  localparam logic [11:0] RST_MARGIN_XY = 12'd100;
  localparam logic [11:0] RST_MARGIN_Z  = 12'd100;
  localparam logic [11:0] RST_RADIUS    = 12'd200;
  localparam logic [15:0] RST_MIN_PTS   = 16'd10;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] track_ident;
    logic               is_table;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic signed [15:0] c_z;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic        matched;
    logic [14:0] out_track;
    logic [15:0] point_count;
    logic        keep;
    logic        last;
  } out_t;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
  } sq_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQRT,
    ST_SCAN,
    ST_PFIN,
    ST_SUM
  } state_e;

endpackage

// ===== sv/ptbta_sq_unit.sv =====
module ptbta_sq_unit (
  input  logic                              clk_i,
  input  logic signed [ptbta_pkg::OPND_W-1:0] operand_i,
  input  ptbta_pkg::sq_ctrl_t               ctrl_i,
  output logic [ptbta_pkg::ACC_W-1:0]       prod_o,
  output logic [ptbta_pkg::ACC_W-1:0]       acc_o
);
  import ptbta_pkg::*;

  logic signed [2*OPND_W-1:0] full;
  logic [ACC_W-1:0] prod_q, acc_q;

  assign full = operand_i * operand_i;

  // register the square, accumulate the registered square in the next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= full[ACC_W-1:0];
    if (ctrl_i.acc_clr) begin
      acc_q <= prod_q;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;
endmodule

// ===== sv/ptbta_isqrt.sv =====
module ptbta_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptbta_pkg::RAD_W-1:0]   value_i,
  output logic                          done_o,
  output logic [ptbta_pkg::ROOT_W-1:0]  root_o
);
  import ptbta_pkg::*;

  logic [RAD_W-1:0] v_q, res_q, bit_q, v_d, res_d, trial;
  logic busy_q;

  assign trial = res_q + bit_q;

  // one result bit a cycle, restoring form
  always_comb begin
    v_d   = v_q;
    res_d = res_q >> 1;
    if (v_q >= trial) begin
      v_d   = v_q - trial;
      res_d = (res_q >> 1) + bit_q;
    end
  end

  assign done_o = busy_q && (bit_q == RAD_W'(1));
  assign root_o = res_d[ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= RAD_W'(1) << (RAD_W - 2);
    end else if (busy_q) begin
      v_q   <= v_d;
      res_q <= res_d;
      bit_q <= bit_q >> 2;
    end
  end
endmodule

// ===== sv/point_to_box_track_attributor.sv =====
// Gated nearest-centroid point attribution. A load transaction stores a table
// track (box, centroid, id) in the next free slot; it squares the box diagonal
// in the shared squaring unit and then takes the bit-serial square root of it.
// A point transaction walks the stored slots through the one squaring unit
// (per slot three squared distances, the radius square, then the compare) and
// gives one result. An end-of-frame transaction gives one summary result for
// each distinct id, or one unmatched result for an empty table, a cycle a slot
// while the output is free, and then clears the table. The input is stalled
// while a transaction is at work; the output register lets the next
// transaction start while a result still waits.
module point_to_box_track_attributor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ptbta_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ptbta_pkg::out_t   out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);
  import ptbta_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [11:0] margin_xy_q, margin_z_q, radius_q;
  logic [15:0] min_pts_q;

  // track table
  logic signed [15:0] lo_q [MAX_TRACKS][3];
  logic signed [15:0] hi_q [MAX_TRACKS][3];
  logic signed [15:0] ce_q [MAX_TRACKS][3];
  logic [15:0]        hd_q [MAX_TRACKS];
  logic [14:0]        ident_q [MAX_TRACKS];
  logic [SLOT_W-1:0]  owner_q [MAX_TRACKS];
  logic [15:0]        hits_q [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] own_mask_q;
  logic [CNT_W-1:0]   used_q;

  // sequencer
  in_t               item_q;
  logic [SLOT_W-1:0] k_q;
  logic [2:0]        ph_q;
  logic              inside_q, found_q;
  logic [SLOT_W-1:0] best_q;
  logic [ACC_W-1:0]  best_d2_q;

  logic  out_valid_q;
  out_t  out_q;

  logic accept, load_ok, out_free, last_slot, fit, emit, clear_frame;
  logic signed [15:0] cur_a, cur_b, cur_lo, cur_hi, cur_ce;
  logic signed [17:0] a_e, lo_m, hi_m;
  logic [11:0] margin;
  logic gate_ok;
  logic [16:0] radius;
  logic signed [OPND_W-1:0] operand;
  sq_ctrl_t sq_ctrl;
  logic [ACC_W-1:0] prod, acc;
  logic sq_start, sq_done;
  logic [ROOT_W-1:0] root;
  logic [SLOT_W-1:0] haddr, new_owner;
  logic [15:0] h_cur, h_inc;
  out_t emit_data;

  function automatic logic keep_f(logic [15:0] cnt, logic [15:0] thr);
    logic [15:0] t;
    t = (thr == 16'd0) ? 16'd1 : thr;
    return cnt >= t;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load_ok    = !in_data_i.track_ident[15] && in_data_i.is_table &&
                      (used_q < CNT_W'(MAX_TRACKS));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_slot  = (({1'b0, k_q} + CNT_W'(1)) == used_q);

  // select the coordinate this phase works on
  always_comb begin
    case (ph_q[1:0])
      2'd0: begin
        cur_a = item_q.a_x; cur_b = item_q.b_x;
      end
      2'd1: begin
        cur_a = item_q.a_y; cur_b = item_q.b_y;
      end
      default: begin
        cur_a = item_q.a_z; cur_b = item_q.b_z;
      end
    endcase
    cur_lo = lo_q[k_q][(ph_q > 3'd2) ? 2'd2 : ph_q[1:0]];
    cur_hi = hi_q[k_q][(ph_q > 3'd2) ? 2'd2 : ph_q[1:0]];
    cur_ce = ce_q[k_q][(ph_q > 3'd2) ? 2'd2 : ph_q[1:0]];
  end

  // box gate for one coordinate, widened by the margin
  assign margin  = (ph_q == 3'd2) ? margin_z_q : margin_xy_q;
  assign a_e     = {{2{cur_a[15]}}, cur_a};
  assign lo_m    = {{2{cur_lo[15]}}, cur_lo} - $signed({6'b0, margin});
  assign hi_m    = {{2{cur_hi[15]}}, cur_hi} + $signed({6'b0, margin});
  assign gate_ok = !(a_e < lo_m) && !(a_e > hi_m);

  assign radius = {1'b0, hd_q[k_q]} + {5'b0, radius_q};

  // feed the squaring unit: differences in phases 0-2, radius in phase 3
  always_comb begin
    operand = '0;
    if (state_q == ST_LOAD && ph_q < 3'd3) begin
      operand = {{2{cur_b[15]}}, cur_b} - {{2{cur_a[15]}}, cur_a};
    end else if (state_q == ST_SCAN && ph_q < 3'd3) begin
      operand = a_e - {{2{cur_ce[15]}}, cur_ce};
    end else if (state_q == ST_SCAN && ph_q == 3'd3) begin
      operand = {1'b0, radius};
    end
    sq_ctrl.acc_clr = (state_q == ST_LOAD || state_q == ST_SCAN) && (ph_q == 3'd1);
    sq_ctrl.acc_en  = (state_q == ST_LOAD || state_q == ST_SCAN) &&
                      (ph_q == 3'd2 || ph_q == 3'd3);
  end

  ptbta_sq_unit u_sq (
    .clk_i     (clk_i),
    .operand_i (operand),
    .ctrl_i    (sq_ctrl),
    .prod_o    (prod),
    .acc_o     (acc)
  );

  assign sq_start = (state_q == ST_LOAD) && (ph_q == 3'd4);

  ptbta_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (acc[RAD_W-1:0]),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // in phase 4 the sum of squares sits in acc and the radius square in prod
  assign fit = inside_q && (acc <= prod);

  // first earlier slot holding the same id owns the count
  always_comb begin
    new_owner = used_q[SLOT_W-1:0];
    for (int j = MAX_TRACKS - 1; j >= 0; j--) begin
      if (CNT_W'(j) < used_q && ident_q[j] == in_data_i.track_ident[14:0]) begin
        new_owner = SLOT_W'(j);
      end
    end
  end

  assign haddr = (state_q == ST_SUM) ? k_q : owner_q[best_q];
  assign h_cur = hits_q[haddr];
  assign h_inc = (h_cur == 16'hFFFF) ? h_cur : h_cur + 16'd1;

  always_comb begin
    state_d     = state_q;
    emit        = 1'b0;
    clear_frame = 1'b0;
    emit_data   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.opcode)
            OP_LOAD:  if (load_ok) state_d = ST_LOAD;
            OP_POINT: state_d = (used_q == '0) ? ST_PFIN : ST_SCAN;
            OP_EOF:   state_d = ST_SUM;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (ph_q == 3'd4) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_done) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (ph_q == 3'd4 && last_slot) state_d = ST_PFIN;
      end
      ST_PFIN: begin
        emit_data.last = 1'b1;
        if (found_q) begin
          emit_data.matched     = 1'b1;
          emit_data.out_track   = ident_q[haddr];
          emit_data.point_count = h_inc;
          emit_data.keep        = keep_f(h_inc, min_pts_q);
        end
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        emit_data.result_kind = 1'b1;
        if (used_q == '0) begin
          emit_data.last = 1'b1;
          if (out_free) begin
            emit        = 1'b1;
            clear_frame = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (!own_mask_q[k_q]) begin
          if (last_slot) begin
            clear_frame = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          emit_data.matched     = 1'b1;
          emit_data.out_track   = ident_q[k_q];
          emit_data.point_count = h_cur;
          emit_data.keep        = keep_f(h_cur, min_pts_q);
          emit_data.last        = ((own_mask_q >> k_q) >> 1) == '0;
          if (out_free) begin
            emit = 1'b1;
            if (last_slot) begin
              clear_frame = 1'b1;
              state_d     = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_xy_q <= RST_MARGIN_XY;
      margin_z_q  <= RST_MARGIN_Z;
      radius_q    <= RST_RADIUS;
      min_pts_q   <= RST_MIN_PTS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MARGIN_XY: margin_xy_q <= cfg_data_i[11:0];
        CFG_MARGIN_Z:  margin_z_q  <= cfg_data_i[11:0];
        CFG_RADIUS:    radius_q    <= cfg_data_i[11:0];
        CFG_MIN_PTS:   min_pts_q   <= cfg_data_i;
        default:       min_pts_q   <= min_pts_q;
      endcase
    end
  end

  // frame control and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      own_mask_q  <= '0;
      k_q         <= '0;
      ph_q        <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_TRACKS; j++) hits_q[j] <= '0;
    end else begin
      if (accept) begin
        ph_q    <= '0;
        found_q <= 1'b0;
        if (in_data_i.opcode == OP_LOAD && load_ok) begin
          k_q    <= used_q[SLOT_W-1:0];
          used_q <= used_q + CNT_W'(1);
          if (new_owner == used_q[SLOT_W-1:0]) begin
            own_mask_q[used_q[SLOT_W-1:0]] <= 1'b1;
          end
        end else begin
          k_q <= '0;
        end
      end
      if (state_q == ST_LOAD) begin
        ph_q <= ph_q + 3'd1;
      end
      if (state_q == ST_SCAN) begin
        if (ph_q == 3'd4) begin
          ph_q <= '0;
          if (fit && (!found_q || acc < best_d2_q)) found_q <= 1'b1;
          if (!last_slot) k_q <= k_q + SLOT_W'(1);
        end else begin
          ph_q <= ph_q + 3'd1;
        end
      end
      if (state_q == ST_PFIN && out_free && found_q) begin
        hits_q[haddr] <= h_inc;
      end
      if (state_q == ST_SUM && used_q != '0 && (emit || !own_mask_q[k_q])) begin
        k_q <= k_q + SLOT_W'(1);
      end
      if (clear_frame) begin
        used_q     <= '0;
        own_mask_q <= '0;
        for (int j = 0; j < MAX_TRACKS; j++) hits_q[j] <= '0;
      end
      // hold the result until taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: table, held transaction, running best, result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      if (in_data_i.opcode == OP_LOAD && load_ok) begin
        lo_q[used_q[SLOT_W-1:0]][0]  <= in_data_i.a_x;
        lo_q[used_q[SLOT_W-1:0]][1]  <= in_data_i.a_y;
        lo_q[used_q[SLOT_W-1:0]][2]  <= in_data_i.a_z;
        hi_q[used_q[SLOT_W-1:0]][0]  <= in_data_i.b_x;
        hi_q[used_q[SLOT_W-1:0]][1]  <= in_data_i.b_y;
        hi_q[used_q[SLOT_W-1:0]][2]  <= in_data_i.b_z;
        ce_q[used_q[SLOT_W-1:0]][0]  <= in_data_i.c_x;
        ce_q[used_q[SLOT_W-1:0]][1]  <= in_data_i.c_y;
        ce_q[used_q[SLOT_W-1:0]][2]  <= in_data_i.c_z;
        ident_q[used_q[SLOT_W-1:0]]  <= in_data_i.track_ident[14:0];
        owner_q[used_q[SLOT_W-1:0]]  <= new_owner;
      end
    end
    if (state_q == ST_SQRT && sq_done) begin
      hd_q[k_q] <= root[ROOT_W-1:1];
    end
    if (state_q == ST_SCAN) begin
      if (ph_q == 3'd0) begin
        inside_q <= gate_ok;
      end else if (ph_q < 3'd3) begin
        inside_q <= inside_q && gate_ok;
      end
      // strict compare: the earlier slot wins a tie
      if (ph_q == 3'd4 && fit && (!found_q || acc < best_d2_q)) begin
        best_q    <= k_q;
        best_d2_q <= acc;
      end
    end
    if (emit) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

// ===== tb/tb_point_to_box_track_attributor.sv =====
`timescale 1ns / 100ps

module tb_point_to_box_track_attributor;
  import ptbta_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 60;

  // Track table predictor and store of expected results.
  class attrib_scoreboard;
    int     lo[MAX_TRACKS][3];
    int     hi[MAX_TRACKS][3];
    int     cen[MAX_TRACKS][3];
    longint hdiag[MAX_TRACKS];
    int     ident[MAX_TRACKS];
    int     hits[MAX_TRACKS];
    int     used;
    int     mxy, mz, rext, minpts;
    out_t   awaited[$];
    int     errors;

    function new();
      used = 0; errors = 0;
      mxy = int'(RST_MARGIN_XY); mz = int'(RST_MARGIN_Z);
      rext = int'(RST_RADIUS); minpts = int'(RST_MIN_PTS);
      foreach (hits[k]) hits[k] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_MARGIN_XY: mxy = int'(val[11:0]);
        CFG_MARGIN_Z:  mz = int'(val[11:0]);
        CFG_RADIUS:    rext = int'(val[11:0]);
        default:       minpts = int'(val);
      endcase
    endfunction

    function longint root_floor(longint v);
      longint l, h, m;
      l = 0; h = 200000;
      while (l < h) begin
        m = (l + h + 1) / 2;
        if (m * m <= v) l = m; else h = m - 1;
      end
      return l;
    endfunction

    function bit kept(int cnt);
      return cnt >= ((minpts == 0) ? 1 : minpts);
    endfunction

    function int first_slot(int k);
      for (int j = 0; j < k; j++) if (ident[j] == ident[k]) return j;
      return k;
    endfunction

    function void add_expected(bit kind, bit hit, int id, int cnt, bit kp, bit lst);
      out_t r;
      r.result_kind = kind; r.matched = hit; r.out_track = id[14:0];
      r.point_count = cnt[15:0]; r.keep = kp; r.last = lst;
      awaited.insert(awaited.size(), r);
    endfunction

    // Note an accepted input transaction and queue what it causes.
    function void note_input(in_t it);
      int     p[3], b[3], c[3];
      longint d2, r, best_d2;
      int     best, o, n;
      bit     in_gate, found;
      p = '{int'($signed(it.a_x)), int'($signed(it.a_y)), int'($signed(it.a_z))};
      b = '{int'($signed(it.b_x)), int'($signed(it.b_y)), int'($signed(it.b_z))};
      c = '{int'($signed(it.c_x)), int'($signed(it.c_y)), int'($signed(it.c_z))};
      case (it.opcode)
        OP_LOAD: begin
          if ($signed(it.track_ident) < 0 || !it.is_table || used >= MAX_TRACKS) return;
          d2 = 0;
          for (int i = 0; i < 3; i++) begin
            lo[used][i] = p[i]; hi[used][i] = b[i]; cen[used][i] = c[i];
            d2 += longint'(b[i] - p[i]) * longint'(b[i] - p[i]);
          end
          hdiag[used] = root_floor(d2) / 2;
          ident[used] = int'(it.track_ident);
          hits[used] = 0;
          used++;
        end
        OP_POINT: begin
          found = 0; best = 0; best_d2 = 0;
          for (int k = 0; k < used; k++) begin
            in_gate = 1; d2 = 0;
            for (int i = 0; i < 3; i++) begin
              if (p[i] < lo[k][i] - (i < 2 ? mxy : mz) ||
                  p[i] > hi[k][i] + (i < 2 ? mxy : mz)) in_gate = 0;
              d2 += longint'(p[i] - cen[k][i]) * longint'(p[i] - cen[k][i]);
            end
            r = hdiag[k] + rext;
            if (in_gate && d2 <= r * r && (!found || d2 < best_d2)) begin
              found = 1; best = k; best_d2 = d2;
            end
          end
          if (!found) add_expected(0, 0, 0, 0, 0, 1);
          else begin
            o = first_slot(best);
            if (hits[o] < 65535) hits[o]++;
            add_expected(0, 1, ident[o], hits[o], kept(hits[o]), 1);
          end
        end
        OP_EOF: begin
          n = 0;
          for (int k = 0; k < used; k++) begin
            if (first_slot(k) != k) continue;
            add_expected(1, 1, ident[k], hits[k], kept(hits[k]), 0);
            n++;
          end
          if (n == 0) add_expected(1, 0, 0, 0, 0, 1);
          else awaited[$].last = 1;
          foreach (hits[k]) hits[k] = 0;
          used = 0;
        end
        default: ;  // reserved opcode: dropped
      endcase
    endfunction

    function void check_result(out_t got);
      out_t w;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      w = awaited.pop_front();
      if (got !== w) begin
        $display("%0t: mismatch expected %p actual %p", $realtime, w, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  out_t        out_data_o;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  attrib_scoreboard sb = new();

  // Centroids of tracks loaded this frame, used to aim points.
  int aim_x[$], aim_y[$], aim_z[$], aim_s[$];
  int burst_left = 0;
  bit hold_req = 0;
  int cycles = 0;

  point_to_box_track_attributor uut (.*);

  always #6 clk_i = ~clk_i;

  // Guard against a hang.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL point_to_box_track_attributor");
      $finish;
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);

  // Receiver: stall pattern is chosen at random from three modes; on request hold off
  // for a long stretch so the block fills up and stalls its input.
  initial begin
    int mode, left;
    mode = 0; left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2); left = 64;
        end
        left--;
        case (mode)
          0: out_stall_i <= 0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one transaction and hold it until accepted; then maybe open a gap.
  task automatic send(in_t it);
    int gap;
    in_data_i  <= it;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    if (it.opcode == OP_LOAD && $signed(it.track_ident) >= 0 && it.is_table) begin
      aim_x.insert(aim_x.size(), int'($signed(it.c_x)));
      aim_y.insert(aim_y.size(), int'($signed(it.c_y)));
      aim_z.insert(aim_z.size(), int'($signed(it.c_z)));
      aim_s.insert(aim_s.size(),
                   (int'($signed(it.b_x)) - int'($signed(it.a_x))) / 2 + 1);
    end
    if (it.opcode == OP_EOF) begin
      aim_x.delete(); aim_y.delete(); aim_z.delete(); aim_s.delete();
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end else burst_left--;
  endtask

  // Drain: wait for every expected result, then let a running load finish.
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic in_t noise();
    in_t         it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    return it;
  endfunction

  function automatic in_t mk_load(int id, bit tab, int x0, int y0, int z0,
                                  int x1, int y1, int z1, int cx, int cy, int cz);
    in_t it;
    it = noise();
    it.opcode = OP_LOAD; it.track_ident = 16'(id); it.is_table = tab;
    it.a_x = 16'(x0); it.a_y = 16'(y0); it.a_z = 16'(z0);
    it.b_x = 16'(x1); it.b_y = 16'(y1); it.b_z = 16'(z1);
    it.c_x = 16'(cx); it.c_y = 16'(cy); it.c_z = 16'(cz);
    return it;
  endfunction

  function automatic in_t mk_op(logic [1:0] op, int x, int y, int z);
    in_t it;
    it = noise();
    it.opcode = op; it.a_x = 16'(x); it.a_y = 16'(y); it.a_z = 16'(z);
    return it;
  endfunction

  function automatic int clip(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  // Random table track around a random centre; rarely fully random fields.
  function automatic in_t rand_load();
    in_t it;
    int  cx, cy, cz, s, id;
    if ($urandom_range(0, 15) == 0) begin
      it = noise(); it.opcode = OP_LOAD;
      return it;
    end
    cx = int'($urandom_range(0, 50000)) - 25000;
    cy = int'($urandom_range(0, 50000)) - 25000;
    cz = int'($urandom_range(0, 8000)) - 4000;
    s  = $urandom_range(10, 2500);
    id = $urandom_range(0, 3) == 0 ? int'($urandom & 16'hffff) : int'($urandom_range(0, 30));
    it = mk_load(id, $urandom_range(0, 9) != 0, cx - s, cy - s, cz - s, cx + s, cy + s,
                 cz + s, cx + int'($urandom_range(0, 200)) - 100,
                 cy + int'($urandom_range(0, 200)) - 100, cz);
    if (id >= 32768) it.track_ident = id[15:0];
    return it;
  endfunction

  function automatic in_t rand_point();
    int k, s;
    if (aim_x.size() == 0 || $urandom_range(0, 4) == 0)
      return mk_op(OP_POINT, $urandom, $urandom, $urandom);
    k = $urandom_range(0, aim_x.size() - 1);
    s = aim_s[k] < 1 ? 1 : (aim_s[k] > 4000 ? 4000 : aim_s[k]);
    return mk_op(OP_POINT, clip(aim_x[k] + int'($urandom_range(0, 2 * s)) - s),
                 clip(aim_y[k] + int'($urandom_range(0, 2 * s)) - s),
                 clip(aim_z[k] + int'($urandom_range(0, 2 * s)) - s));
  endfunction

  initial begin
    int sent, nl, np;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // Directed: empty frame, dropped loads, duplicates, inverted box, extremes.
    send(mk_op(OP_EOF, 0, 0, 0));
    send(mk_load(-1, 1, 0, 0, 0, 100, 100, 100, 50, 50, 50));
    send(mk_load(5, 0, 0, 0, 0, 100, 100, 100, 50, 50, 50));
    send(mk_load(7, 1, -100, -100, -100, 100, 100, 100, 0, 0, 0));
    send(mk_load(7, 1, 0, 0, 0, 400, 400, 400, 300, 300, 300));
    send(mk_load(32767, 1, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0));
    send(mk_load(3, 1, 500, 500, 500, -500, -500, -500, 0, 0, 0));
    send(mk_load(0, 1, 5000, 5000, 0, 5000, 5000, 0, 5000, 5000, 0));
    send(mk_op(OP_POINT, 0, 0, 0));
    send(mk_op(OP_POINT, 300, 300, 300));
    send(mk_op(OP_POINT, 32767, 32767, 32767));
    send(mk_op(OP_POINT, -32768, -32768, -32768));
    send(mk_op(OP_POINT, 5000, 5000, 0));
    send(mk_op(2'd3, 0, 0, 0));
    send(mk_op(OP_EOF, 0, 0, 0));
    // Full table: the seventeenth load is dropped.
    for (int k = 0; k < 17; k++)
      send(mk_load(k, 1, k * 1000, 0, 0, k * 1000 + 200, 200, 200, k * 1000 + 100, 100, 100));
    send(mk_op(OP_POINT, 16100, 100, 100));
    send(mk_op(OP_EOF, 0, 0, 0));
    drain();

    // Extremes of every register.
    write_reg(CFG_MARGIN_XY, 16'd0);
    write_reg(CFG_MARGIN_Z, 16'd4095);
    write_reg(CFG_RADIUS, 16'd0);
    write_reg(CFG_MIN_PTS, 16'd0);

    sent = 0;
    while (sent < 350) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        for (int r = 0; r < 4; r++)
          if ($urandom_range(0, 1))
            write_reg(r[1:0], $urandom_range(0, 3) == 0 ?
                      ($urandom_range(0, 1) ? 16'hffff : 16'd0) : 16'($urandom_range(0, 600)));
      end
      nl = $urandom_range(0, 5) == 0 ? $urandom_range(14, 18) : $urandom_range(0, 6);
      np = $urandom_range(4, 20);
      for (int k = 0; k < nl; k++) begin send(rand_load()); sent++; end
      if (sent > 120 && sent < 160) hold_req = 1;
      for (int k = 0; k < np; k++) begin
        send($urandom_range(0, 40) == 0 ? mk_op(2'd3, 0, 0, 0) : rand_point());
        sent++;
      end
      send(mk_op(OP_EOF, 0, 0, 0)); sent++;
    end

    drain();
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASS point_to_box_track_attributor");
    end else begin
      $display("FAIL point_to_box_track_attributor");
    end
    $finish;
  end

endmodule

// ===== point_to_box_track_attributor.f =====
sv/ptbta_pkg.sv
sv/ptbta_sq_unit.sv
sv/ptbta_isqrt.sv
sv/point_to_box_track_attributor.sv
tb/tb_point_to_box_track_attributor.sv
